[rtl/pfa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the first-fit page frame allocator.
// ---------------------------------------------------------------------------
package pfa_pkg;

    // Sizing
    localparam int FRAME_SLOTS = 64;
    localparam int MAX_PROCS  = 24;

    localparam int FRAME_W    = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int FREE_W     = $clog2(FRAME_SLOTS + 1);
    localparam int PCOUNT_W   = $clog2(MAX_PROCS + 1);

    // Field widths
    localparam int ID_W       = 8;
    localparam int BYTES_W    = 14;
    localparam int PSIZE_W    = 8;
    localparam int FCOUNT_W   = 7;
    localparam int PAGE_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Page count numerator is bytes + psize - 1, one bit wider than bytes
    localparam int NUM_W      = BYTES_W + 1;
    localparam int DIV_STEPS  = NUM_W;

    // Free-frame census runs eight frames per cycle
    localparam int LANES      = 8;
    localparam int CHUNKS     = (FRAME_SLOTS + LANES - 1) / LANES;
    localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CALC_STEPS = (DIV_STEPS > CHUNKS) ? DIV_STEPS : CHUNKS;
    localparam int STEP_W     = $clog2(CALC_STEPS);

    typedef enum logic [2:0] {
        ST_MAPPED     = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_NO_FRAMES  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_PAGE_BYTES  = 2'd1,
        CFG_MAX_BYTES   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_SCAN
    } back_state_t;

    typedef struct packed {
        logic [FCOUNT_W-1:0]   frame_count;
        logic [PSIZE_W-1:0]    page_bytes;
        logic [CFG_DATA_W-1:0] max_process_bytes;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]    proc_id;
        logic [BYTES_W-1:0] proc_bytes;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   owner_id;
        logic [PAGE_W-1:0] page_number;
        logic [PAGE_W-1:0] frame_number;
        logic              last;
    } result_t;

    // Classified request handed from front to back
    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic [FREE_W-1:0] pages;
    } job_t;

endpackage

[rtl/pfa_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_front
// Accepts a request, works out its page count and the free frames, and
// classifies it into a job for the back end.
// ---------------------------------------------------------------------------
module pfa_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  pfa_pkg::req_t                      req,
    input  pfa_pkg::cfg_t                      cfg,
    input  logic [pfa_pkg::FRAME_SLOTS-1:0]    frame_free,
    input  logic                               q_full,
    output logic                               q_push,
    output pfa_pkg::job_t                      q_data,
    output logic                               idle
);
    import pfa_pkg::*;

    front_state_t          state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [BYTES_W-1:0]    bytes_reg, bytes_next;
    logic [NUM_W-1:0]      quo_reg, quo_next;
    logic [PSIZE_W-1:0]    rem_reg, rem_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [PCOUNT_W-1:0]   pcount_reg, pcount_next;

    logic [PSIZE_W-1:0]    psize;
    logic [FCOUNT_W-1:0]   active;
    logic [CHUNKS*LANES-1:0] padded;
    logic [LANES-1:0]      chunk_bits;
    logic [CHUNK_W-1:0]    chunk;
    logic [FREE_W-1:0]     chunk_free;
    logic [PSIZE_W:0]      rem_shift;
    logic                  ge;
    logic                  too_large;
    logic                  no_frames;
    logic                  table_full;

    assign psize  = (cfg.page_bytes == '0) ? PSIZE_W'(1) : cfg.page_bytes;
    assign active = (cfg.frame_count > FCOUNT_W'(FRAME_SLOTS)) ?
                    FCOUNT_W'(FRAME_SLOTS) : cfg.frame_count;
    assign padded = (CHUNKS*LANES)'(frame_free);
    assign chunk  = step_reg[CHUNK_W-1:0];
    assign chunk_bits = padded[chunk*LANES +: LANES];

    // Census of one chunk of eight frames, only those below the active count
    always_comb
    begin
        chunk_free = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (chunk_bits[j] &&
                (FCOUNT_W'({chunk, 3'(j)}) < active))
            begin
                chunk_free = chunk_free + FREE_W'(1);
            end
        end
    end

    // One restoring division step: quotient bits shift in behind the numerator
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign ge        = (rem_shift >= {1'b0, psize});

    assign too_large  = (bytes_reg > cfg.max_process_bytes);
    assign no_frames  = (NUM_W'(free_reg) < quo_reg);
    assign table_full = (pcount_reg >= PCOUNT_W'(MAX_PROCS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            pcount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pcount_reg <= pcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        id_reg    <= id_next;
        bytes_reg <= bytes_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        free_reg  <= free_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        id_next     = id_reg;
        bytes_next  = bytes_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        free_next   = free_reg;
        pcount_next = pcount_reg;
        q_push      = 1'b0;
        q_data      = '{status: ST_MAPPED, id: id_reg, pages: FREE_W'(quo_reg)};
        idle        = (state_reg == F_IDLE);

        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    id_next    = req.proc_id;
                    bytes_next = req.proc_bytes;
                    quo_next   = NUM_W'(req.proc_bytes) + NUM_W'(psize) - NUM_W'(1);
                    rem_next   = '0;
                    free_next  = '0;
                    step_next  = '0;
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                if (32'(step_reg) < DIV_STEPS)
                begin
                    quo_next = {quo_reg[NUM_W-2:0], ge};
                    rem_next = ge ? PSIZE_W'(rem_shift - {1'b0, psize})
                                  : rem_shift[PSIZE_W-1:0];
                end
                if (32'(step_reg) < CHUNKS)
                begin
                    free_next = free_reg + chunk_free;
                end
                if (32'(step_reg) == CALC_STEPS - 1)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            F_PUSH:
            begin
                if (too_large)
                begin
                    q_data.status = ST_TOO_LARGE;
                end
                else if (no_frames)
                begin
                    q_data.status = ST_NO_FRAMES;
                end
                else if (table_full)
                begin
                    q_data.status = ST_TABLE_FULL;
                end
                else if (quo_reg == '0)
                begin
                    q_data.status = ST_EMPTY;
                end
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                    if (!too_large && !no_frames && !table_full)
                    begin
                        pcount_next = pcount_reg + PCOUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    a_pcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= PCOUNT_W'(MAX_PROCS))
        else $error("process count beyond table size");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && (q_data.status == ST_MAPPED || q_data.status == ST_EMPTY))
        |=> (pcount_reg == $past(pcount_reg) + PCOUNT_W'(1)))
        else $error("accepted request did not take a table slot");

endmodule

[rtl/pfa_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_queue
// Two-entry job queue between classifier and frame scanner.
// ---------------------------------------------------------------------------
module pfa_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pfa_pkg::job_t push_data,
    input  logic          pop,
    output pfa_pkg::job_t pop_data,
    output logic          full,
    output logic          empty
);
    import pfa_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ (push && !full);
        rd_ptr_next = rd_ptr_reg ^ (pop && !empty);
        count_next  = count_reg + 2'((push && !full) ? 1 : 0)
                                - 2'((pop && !empty) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into full queue");

endmodule

[rtl/pfa_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_back
// Owns the free-frame bitmap; scans it first-fit and emits one mapping
// per page, or a single status result for other jobs.
// ---------------------------------------------------------------------------
module pfa_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  pfa_pkg::job_t                   q_data,
    output logic                            q_pop,
    output logic [pfa_pkg::FRAME_SLOTS-1:0] frame_free,
    output logic                            scanning,
    output logic                            result_valid,
    output pfa_pkg::result_t                result
);
    import pfa_pkg::*;

    back_state_t             state_reg, state_next;
    logic [FRAME_SLOTS-1:0]  free_reg, free_next;
    logic [FRAME_W-1:0]      frame_reg, frame_next;
    logic [FRAME_W-1:0]      done_reg, done_next;
    logic [FREE_W-1:0]       pages_reg, pages_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic                    valid_reg, valid_next;
    result_t                 result_reg, result_next;
    logic                    is_last;

    assign frame_free   = free_reg;
    assign scanning     = (state_reg != B_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;
    assign is_last      = ((FREE_W'(done_reg) + FREE_W'(1)) == pages_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            free_reg  <= '1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        done_reg   <= done_next;
        pages_reg  <= pages_next;
        id_reg     <= id_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        free_next   = free_reg;
        frame_next  = frame_reg;
        done_next   = done_reg;
        pages_next  = pages_reg;
        id_next     = id_reg;
        valid_next  = 1'b0;
        result_next = result_reg;
        q_pop       = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_data.status == ST_MAPPED)
                    begin
                        id_next    = q_data.id;
                        pages_next = q_data.pages;
                        frame_next = '0;
                        done_next  = '0;
                        state_next = B_SCAN;
                    end
                    else
                    begin
                        valid_next  = 1'b1;
                        result_next = '{status: q_data.status, owner_id: q_data.id,
                                        page_number: '0, frame_number: '0,
                                        last: 1'b1};
                    end
                end
            end
            B_SCAN:
            begin
                // The classifier guaranteed enough free frames below the
                // active count, so the scan finishes before running past it.
                if (free_reg[frame_reg])
                begin
                    free_next[frame_reg] = 1'b0;
                    valid_next  = 1'b1;
                    result_next = '{status: ST_MAPPED, owner_id: id_reg,
                                    page_number: PAGE_W'(done_reg),
                                    frame_number: PAGE_W'(frame_reg),
                                    last: is_last};
                    done_next   = done_reg + FRAME_W'(1);
                    if (is_last)
                    begin
                        state_next = B_IDLE;
                    end
                end
                frame_next = frame_reg + FRAME_W'(1);
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.status != ST_MAPPED) |-> result_reg.last)
        else $error("status result without last mark");

    a_frame_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.status == ST_MAPPED)
        |-> !free_reg[FRAME_W'(result_reg.frame_number)])
        else $error("mapped frame still marked free");

endmodule

[rtl/page_frame_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_frame_allocator
// First-fit page frame allocator: process creation requests in, one
// page-to-frame mapping per page (or one status result) out.
// ---------------------------------------------------------------------------
// A request (proc_id, proc_bytes) is taken when start is high and busy is
// low. Results come out on result with a one-cycle result_valid strobe; the
// receiver cannot stall, so every strobe must be captured. A rejected or
// zero-size request gives one result; a mapped request gives one result per
// page in ascending page order, frames taken lowest first, and last marks
// the final result of the request. Each request is accepted and then
// classified (a bit-per-cycle page-count divider running alongside an
// eight-frames-per-cycle free-frame census); its job is queued and then
// picked up, and a mapping request then walks the bitmap one frame per
// cycle until its last page is placed. busy stays high from the accept
// until the last result is on the port. Configuration writes are taken on
// the cfg channel while busy and start are both low, so a write never
// lands alongside a request.
// ---------------------------------------------------------------------------
module page_frame_allocator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pfa_pkg::req_t                     req,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              result_valid,
    output pfa_pkg::result_t                  result
);
    import pfa_pkg::*;

    cfg_t                   cfg_reg, cfg_next;
    logic                   accept;
    logic                   front_idle;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    job_t                   push_job;
    job_t                   pop_job;
    logic                   back_scanning;
    logic [FRAME_SLOTS-1:0] frame_free;

    // Busy covers classification, a queued job and the frame scan. The last
    // result may still sit on the port when busy drops; it is already final.
    assign busy      = !front_idle || !q_empty || back_scanning;
    assign accept    = start && !busy;
    // A pending request has priority; the settings stay fixed while it runs
    assign cfg_ready = !busy && !start;

    // Configuration registers; an unknown index is ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_COUNT: cfg_next.frame_count       = cfg_data[FCOUNT_W-1:0];
                CFG_PAGE_BYTES:  cfg_next.page_bytes        = cfg_data[PSIZE_W-1:0];
                CFG_MAX_BYTES:   cfg_next.max_process_bytes = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count       <= FCOUNT_W'(64);
            cfg_reg.page_bytes        <= PSIZE_W'(8);
            cfg_reg.max_process_bytes <= CFG_DATA_W'(1024);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: page count, free census, classification
    pfa_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (req),
        .cfg        (cfg_reg),
        .frame_free (frame_free),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_job),
        .idle       (front_idle)
    );

    // Job queue between the two halves
    pfa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .pop       (q_pop),
        .pop_data  (pop_job),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: bitmap owner, first-fit scan, result register
    pfa_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (pop_job),
        .q_pop        (q_pop),
        .frame_free   (frame_free),
        .scanning     (back_scanning),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
